// ===== hw/rtl/masked_centered_gradient_3d_defines.svh =====
// ----------------------------------------------------------------------------
// masked centered gradient assertion macros
// assertion helpers used by the gradient controller
// ----------------------------------------------------------------------------
`ifndef MASKED_CENTERED_GRADIENT_3D_DEFINES_SVH
`define MASKED_CENTERED_GRADIENT_3D_DEFINES_SVH
`ifndef SYNTHESIS
`define MCG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MCG_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define MCG_ASSERT(lbl, clk, rstn, prop, msg)
`define MCG_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

// ===== hw/rtl/mcg_pkg.sv =====
// ----------------------------------------------------------------------------
// mcg_pkg
// types and constants shared by the gradient controller and datapath
// ----------------------------------------------------------------------------
package mcg_pkg;
  localparam int unsigned MaxSideI = 32;
  localparam int unsigned MaxSideJ = 32;
  localparam int unsigned MaxSideK = 32;
  localparam int unsigned CoordW = 5;
  localparam int unsigned SizeW = 6;
  localparam int unsigned AddrW = 15;
  localparam int unsigned SqrtSteps = 33;
  localparam int unsigned DivSteps = 49;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusMasked = 2'd1;
  localparam logic [1:0] StatusRange  = 2'd2;

  localparam logic [2:0] RegSizeI = 3'd0;
  localparam logic [2:0] RegSizeJ = 3'd1;
  localparam logic [2:0] RegSizeK = 3'd2;
  localparam logic [2:0] RegInvI  = 3'd3;
  localparam logic [2:0] RegInvJ  = 3'd4;
  localparam logic [2:0] RegInvK  = 3'd5;
  localparam logic [2:0] RegNorm  = 3'd6;

  // neighbor read slot: 0 center, 1..6 = i-,i+,j-,j+,k-,k+
  typedef enum logic [2:0] {
    SlotC = 3'd0, SlotIp = 3'd1, SlotIn = 3'd2, SlotJp = 3'd3,
    SlotJn = 3'd4, SlotKp = 3'd5, SlotKn = 3'd6, SlotNone = 3'd7
  } slot_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       latch;     // capture request
    logic       store;     // write voxel
    logic       rd_en;     // issue read
    slot_e      rd_slot;   // slot being read
    slot_e      cap_slot;  // slot of data arriving now
    logic       scale;     // scale axis
    logic [1:0] axis;      // axis to scale
    logic       sq_start;
    logic       sq_step;
    logic       dv_start;
    logic       dv_step;
    logic       dv_fin;
    logic [1:0] dv_axis;
    logic       emit;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic mode;
    logic in_box;
    logic masked;
    logic norm;
  } sts_t;
endpackage

// ===== hw/rtl/masked_centered_gradient_3d.sv =====
// a compute request is decoded, makes 7 memory reads, scales three axes,
// runs a 33-step sqrt and, with normalization, three 48-step divides
// sharing one divider; one request at a time; a store writes its voxel if in range
// out-of-range and masked computes strobe without the sqrt; results never stall
// reset clears control and config; voxel memory is undefined until written
// ----------------------------------------------------------------------------
// masked_centered_gradient_3d
// top level: config registers, controller and datapath
// ----------------------------------------------------------------------------
module masked_centered_gradient_3d import mcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [4:0]  coord_i_i,
  input  logic [4:0]  coord_j_i,
  input  logic [4:0]  coord_k_i,
  input  logic signed [15:0] sample_i,
  input  logic        in_mask_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  output logic        strobe_o,
  output logic [1:0]  status_o,
  output logic signed [31:0] grad_i_o,
  output logic signed [31:0] grad_j_o,
  output logic signed [31:0] grad_k_o,
  output logic [31:0] magnitude_o
);
  logic [5:0] si_q, sj_q, sk_q;
  logic [23:0] ii_q, ij_q, ik_q;
  logic norm_q;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      si_q <= 6'd32; sj_q <= 6'd32; sk_q <= 6'd32;
      ii_q <= 24'd65536; ij_q <= 24'd65536; ik_q <= 24'd65536;
      norm_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSizeI: si_q <= cfg_data_i[5:0];
        RegSizeJ: sj_q <= cfg_data_i[5:0];
        RegSizeK: sk_q <= cfg_data_i[5:0];
        RegInvI:  ii_q <= cfg_data_i;
        RegInvJ:  ij_q <= cfg_data_i;
        RegInvK:  ik_q <= cfg_data_i;
        RegNorm:  norm_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  mcg_ctrl u_ctrl (
    .clk_i, .rst_ni, .start, .busy, .sts_i(sts), .cmd_o(cmd)
  );

  mcg_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .mode_i, .coord_i_i, .coord_j_i, .coord_k_i, .sample_i, .in_mask_i,
    .size_i_i(si_q), .size_j_i(sj_q), .size_k_i(sk_q),
    .inv_i_i(ii_q), .inv_j_i(ij_q), .inv_k_i(ik_q), .norm_i(norm_q),
    .valid_o(strobe_o), .status_o, .grad_i_o, .grad_j_o, .grad_k_o, .magnitude_o
  );
endmodule

// ===== hw/rtl/mcg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcg_ctrl
// sequencer stepping one request through store or reads, scale, sqrt, divides
// ----------------------------------------------------------------------------
`include "masked_centered_gradient_3d_defines.svh"
module mcg_ctrl import mcg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  sts_t sts_i,
  output cmd_t cmd_o
);
  typedef enum logic [7:0] {
    StIdle = 8'b00000001, StDecode = 8'b00000010, StRead = 8'b00000100,
    StScale = 8'b00001000, StSqrt = 8'b00010000, StDiv = 8'b00100000,
    StDone = 8'b01000000, StWait = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic [1:0] ax_q, ax_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      ax_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ax_q    <= ax_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ax_d    = ax_q;
    cmd_o   = '0;
    cmd_o.rd_slot  = SlotNone;
    cmd_o.cap_slot = SlotNone;
    cmd_o.axis     = ax_q;
    cmd_o.dv_axis  = ax_q;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.latch = 1'b1;
          state_d = StDecode;
        end
      end
      StDecode: begin
        if (sts_i.mode == 1'b0) begin
          cmd_o.store = 1'b1;
          state_d = StIdle;
        end else if (!sts_i.in_box) begin
          state_d = StDone;
        end else begin
          cnt_d = '0;
          state_d = StRead;
        end
      end
      StRead: begin
        // read slots 0..6, data returns in the next cycle
        if (cnt_q < 6'd7) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_slot = slot_e'(cnt_q[2:0]);
        end
        if (cnt_q != 6'd0) cmd_o.cap_slot = slot_e'(3'(cnt_q - 6'd1));
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = StWait;
        end
        if (cnt_q == 6'd7) begin
          ax_d = '0;
          state_d = StScale;
        end
      end
      StWait: begin
        // check the center mask after it arrives, i- data lands now
        cmd_o.cap_slot = SlotIp;
        if (sts_i.masked) begin
          state_d = StDone;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_slot = slot_e'(cnt_q[2:0]);
          cnt_d = cnt_q + 6'd1;
          state_d = StRead;
        end
      end
      StScale: begin
        cmd_o.scale = 1'b1;
        ax_d = ax_q + 2'd1;
        if (ax_q == 2'd2) begin
          cnt_d = '0;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        // load the radicand once all three components are in, then step
        if (cnt_q == 6'd0) cmd_o.sq_start = 1'b1;
        else cmd_o.sq_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SqrtSteps)) begin
          if (sts_i.norm) begin
            ax_d = '0;
            state_d = StDiv;
            cnt_d = '0;
          end else begin
            state_d = StDone;
          end
        end
      end
      StDiv: begin
        if (cnt_q == 6'd0) cmd_o.dv_start = 1'b1;
        else cmd_o.dv_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps)) begin
          cmd_o.dv_step = 1'b0;
          cmd_o.dv_fin = 1'b1;
          cnt_d = '0;
          ax_d = ax_q + 2'd1;
          if (ax_q == 2'd2) state_d = StDone;
        end
      end
      StDone: begin
        cmd_o.emit = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  assign busy = (state_q != StIdle);

  `MCG_ASSERT(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `MCG_ASSERT(a_emit_idle, clk_i, rst_ni, cmd_o.emit |=> !busy, "emit not followed by idle")
  `MCG_ASSERT_NEVER(a_latch_busy, clk_i, rst_ni, cmd_o.latch && busy, "latch while busy")
endmodule

// ===== hw/rtl/mcg_datapath.sv =====
// ----------------------------------------------------------------------------
// mcg_datapath
// voxel memory, difference scaling, sqrt and divide units
// ----------------------------------------------------------------------------
module mcg_datapath import mcg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic        mode_i,
  input  logic [4:0]  coord_i_i,
  input  logic [4:0]  coord_j_i,
  input  logic [4:0]  coord_k_i,
  input  logic signed [15:0] sample_i,
  input  logic        in_mask_i,
  input  logic [5:0]  size_i_i,
  input  logic [5:0]  size_j_i,
  input  logic [5:0]  size_k_i,
  input  logic [23:0] inv_i_i,
  input  logic [23:0] inv_j_i,
  input  logic [23:0] inv_k_i,
  input  logic        norm_i,
  output logic        valid_o,
  output logic [1:0]  status_o,
  output logic signed [31:0] grad_i_o,
  output logic signed [31:0] grad_j_o,
  output logic signed [31:0] grad_k_o,
  output logic [31:0] magnitude_o
);
  logic [16:0] mem [2**AddrW];
  logic [16:0] rdata_q;

  logic mode_q, mask_q;
  logic [4:0] ci_q, cj_q, ck_q;
  logic signed [15:0] smp_q;
  logic [5:0] ni_q, nj_q, nk_q;
  logic inside_q, masked_q;
  logic signed [15:0] v_q [7];
  logic signed [31:0] g_q [3];
  logic [65:0] rem_q, rad_q;
  logic [32:0] root_q;
  logic [63:0] num_q;
  logic [48:0] quo_q;
  logic [33:0] drem_q;
  logic [1:0] stat_q;
  logic valid_q;

  function automatic logic [5:0] eff(input logic [5:0] r, input int unsigned mx);
    logic [5:0] m;
    m = 6'(mx);
    if (r < 6'd2) return 6'd2;
    if (r > m) return m;
    return r;
  endfunction

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q <= mode_i;
      ci_q <= coord_i_i; cj_q <= coord_j_i; ck_q <= coord_k_i;
      smp_q <= sample_i; mask_q <= in_mask_i;
      ni_q <= eff(size_i_i, MaxSideI);
      nj_q <= eff(size_j_i, MaxSideJ);
      nk_q <= eff(size_k_i, MaxSideK);
    end
  end

  assign inside_q = ({1'b0, ci_q} < ni_q) && ({1'b0, cj_q} < nj_q) &&
                    ({1'b0, ck_q} < nk_q);

  // read address per slot; edge neighbors may wrap, value is unused there
  logic [4:0] ai, aj, ak;
  always_comb begin
    ai = ci_q; aj = cj_q; ak = ck_q;
    case (cmd_i.rd_slot)
      SlotIp: ai = ci_q - 5'd1;
      SlotIn: ai = ci_q + 5'd1;
      SlotJp: aj = cj_q - 5'd1;
      SlotJn: aj = cj_q + 5'd1;
      SlotKp: ak = ck_q - 5'd1;
      SlotKn: ak = ck_q + 5'd1;
      default: ;
    endcase
  end

  // voxel memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && inside_q) mem[{ci_q, cj_q, ck_q}] <= {mask_q, smp_q};
    if (cmd_i.rd_en) rdata_q <= mem[{ai, aj, ak}];
  end

  // neighbor capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_slot != SlotNone) v_q[cmd_i.cap_slot] <= rdata_q[15:0];
    if (cmd_i.cap_slot == SlotC) masked_q <= !rdata_q[16];
  end

  // axis difference in units of 2^-7, with inv in units of 2^-16
  logic [4:0] pos;
  logic [5:0] n;
  logic signed [15:0] vp, vn, vc;
  logic signed [17:0] dif;
  logic [17:0] adif;
  logic [41:0] prod;
  logic [33:0] q;
  logic signed [31:0] gsat;
  logic [23:0] inv;
  always_comb begin
    vc = v_q[0];
    case (cmd_i.axis)
      2'd0: begin pos = ci_q; n = ni_q; vp = v_q[1]; vn = v_q[2]; inv = inv_i_i; end
      2'd1: begin pos = cj_q; n = nj_q; vp = v_q[3]; vn = v_q[4]; inv = inv_j_i; end
      default: begin pos = ck_q; n = nk_q; vp = v_q[5]; vn = v_q[6]; inv = inv_k_i; end
    endcase
    if (pos == 5'd0) dif = 18'(2 * (18'(vn) - 18'(vc)));
    else if ({1'b0, pos} == n - 6'd1) dif = 18'(2 * (18'(vc) - 18'(vp)));
    else dif = 18'(vn) - 18'(vp);
    adif = dif[17] ? 18'(-dif) : dif;
    prod = 42'(adif) * 42'(inv);
    q = 34'((prod + 42'd256) >> 9);
    if (dif[17]) gsat = (q > 34'h80000000) ? 32'sh80000000 : 32'(-q);
    else gsat = (q > 34'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(q);
  end

  // components: scaled, then normalized if enabled and mag nonzero
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      g_q[cmd_i.axis] <= gsat;
    end else if (cmd_i.dv_fin && mag != 32'd0) begin
      g_q[cmd_i.dv_axis] <= g_q[cmd_i.dv_axis][31] ? 32'(-quo_q) : 32'(quo_q);
    end
  end

  // sum of squares, loaded into the radicand at sqrt start
  logic [31:0] a0, a1, a2;
  logic [65:0] sumsq;
  assign a0 = g_q[0][31] ? 32'(-g_q[0]) : g_q[0];
  assign a1 = g_q[1][31] ? 32'(-g_q[1]) : g_q[1];
  assign a2 = g_q[2][31] ? 32'(-g_q[2]) : g_q[2];
  assign sumsq = 66'(a0) * 66'(a0) + 66'(a1) * 66'(a1) + 66'(a2) * 66'(a2);

  // restoring sqrt, two radicand bits a step
  logic [34:0] trial;
  logic [34:0] rtop;
  assign rtop  = {rem_q[32:0], rad_q[65:64]};
  assign trial = {root_q, 2'b01};
  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_start) begin
      rad_q <= sumsq; rem_q <= '0; root_q <= '0;
    end else if (cmd_i.sq_step) begin
      rad_q <= rad_q << 2;
      if (rtop >= trial) begin
        rem_q <= 66'(rtop - trial);
        root_q <= {root_q[31:0], 1'b1};
      end else begin
        rem_q <= 66'(rtop);
        root_q <= {root_q[31:0], 1'b0};
      end
    end
  end

  logic [31:0] mag;
  assign mag = root_q[32] ? 32'hFFFFFFFF : root_q[31:0];

  // restoring divider for normalization
  logic [31:0] ga;
  logic [34:0] dshift;
  assign ga = g_q[cmd_i.dv_axis][31] ? 32'(-g_q[cmd_i.dv_axis]) : g_q[cmd_i.dv_axis];
  assign dshift = {drem_q, num_q[63]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.dv_start) begin
      num_q <= {ga, 16'd0, 16'd0} + {16'd0, 1'b0, mag[31:1], 16'd0};
      drem_q <= '0; quo_q <= '0;
    end else if (cmd_i.dv_step) begin
      num_q <= num_q << 1;
      if (dshift >= 35'(mag)) begin
        drem_q <= 34'(dshift - 35'(mag));
        quo_q <= {quo_q[47:0], 1'b1};
      end else begin
        drem_q <= 34'(dshift);
        quo_q <= {quo_q[47:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else valid_q <= cmd_i.emit;
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      stat_q <= !inside_q ? StatusRange : (masked_q ? StatusMasked : StatusOk);
      grad_i_o <= (inside_q && !masked_q) ? g_q[0] : '0;
      grad_j_o <= (inside_q && !masked_q) ? g_q[1] : '0;
      grad_k_o <= (inside_q && !masked_q) ? g_q[2] : '0;
      magnitude_o <= (inside_q && !masked_q) ? mag : '0;
    end
  end

  assign valid_o  = valid_q;
  assign status_o = stat_q;
  assign sts_o.mode   = mode_q;
  assign sts_o.in_box = inside_q;
  assign sts_o.masked = masked_q;
  assign sts_o.norm   = norm_i;
endmodule
